@@ rtl/mmsh_pkg.sv @@
// Package for the multi-mode string hash: mode codes, register indexes,
// seed constants and the per-mode initial hash. No dependencies.
package mmsh_pkg;

   typedef logic [2:0] mode_type;
   typedef logic [31:0] word_type;

   // Mode register codes (6 and 7 fall back to BKDR)
   localparam mode_type MODE_BKDR = 3'd0;
   localparam mode_type MODE_DJB  = 3'd1;
   localparam mode_type MODE_SDBM = 3'd2;
   localparam mode_type MODE_RS   = 3'd3;
   localparam mode_type MODE_JS   = 3'd4;
   localparam mode_type MODE_ELF  = 3'd5;

   // Register indexes on the csr port
   localparam logic REG_MODE = 1'b0;
   localparam logic REG_BKDR = 1'b1;

   localparam word_type INIT_DJB     = 32'd5381;
   localparam word_type INIT_JS      = 32'd1315423911;
   localparam word_type RS_START     = 32'd63689;
   localparam word_type RS_STEP      = 32'd378551;
   localparam word_type ELF_TOP      = 32'hF000_0000;
   localparam word_type BKDR_DEFAULT = 32'd131;

   function automatic word_type initial_hash(input mode_type m);
      word_type h;
      unique case (m)
         MODE_DJB: begin
            h = INIT_DJB;
         end
         MODE_JS: begin
            h = INIT_JS;
         end
         default: begin
            h = '0;
         end
      endcase
      return h;
   endfunction

endpackage

@@ rtl/mmsh_fold.sv @@
// Per-byte fold of the running hash for all six modes, combinational.
// Depends on mmsh_pkg.
module mmsh_fold (
   input  mmsh_pkg::mode_type mode,
   input  mmsh_pkg::word_type bkdr_mult,
   input  mmsh_pkg::word_type hash_cur,
   input  mmsh_pkg::word_type rs_cur,
   input  logic [7:0]         char_byte,
   output mmsh_pkg::word_type hash_next,
   output mmsh_pkg::word_type rs_next
);

   mmsh_pkg::word_type c_ext;
   mmsh_pkg::word_type mul_op;
   mmsh_pkg::word_type mul_prod;
   mmsh_pkg::word_type rs_prod;
   mmsh_pkg::word_type elf_sum;
   mmsh_pkg::word_type elf_top;

   // signed char semantics
   assign c_ext = {{24{char_byte[7]}}, char_byte};

   // 32x32 multiplier shared by BKDR and RS, low word only; the RS factor step has its own multiply
   assign mul_op   = (mode == mmsh_pkg::MODE_RS) ? rs_cur : bkdr_mult;
   assign mul_prod = hash_cur * mul_op;
   assign rs_prod  = rs_cur * mmsh_pkg::RS_STEP;

   // ELF: xor/clear are no-ops when the top nibble is zero
   assign elf_sum = {hash_cur[27:0], 4'd0} + c_ext;
   assign elf_top = elf_sum & mmsh_pkg::ELF_TOP;

   always_comb begin
      rs_next = rs_cur;
      unique case (mode)
         mmsh_pkg::MODE_DJB: begin
            hash_next = hash_cur + {hash_cur[26:0], 5'd0} + c_ext;
         end
         mmsh_pkg::MODE_SDBM: begin
            hash_next = c_ext + {hash_cur[25:0], 6'd0} + {hash_cur[15:0], 16'd0} - hash_cur;
         end
         mmsh_pkg::MODE_RS: begin
            hash_next = mul_prod + c_ext;
            rs_next   = rs_prod;
         end
         mmsh_pkg::MODE_JS: begin
            hash_next = hash_cur ^ ({hash_cur[26:0], 5'd0} + c_ext + {2'd0, hash_cur[31:2]});
         end
         mmsh_pkg::MODE_ELF: begin
            hash_next = (elf_sum ^ {24'd0, elf_top[31:24]}) & ~elf_top;
         end
         default: begin
            hash_next = mul_prod + c_ext;
         end
      endcase
   end

endmodule

@@ rtl/multi_mode_string_hash.sv @@
// Multi-mode string hash: one string byte per cycle unless an end transaction waits, 31-bit hash out per string.
// Result path: an accepted end transaction passes the input stage register, then the output register (rsp_tvalid).
// Throughput: 1 transaction per cycle unless an end transaction waits; the hash loop is one 32x32 low-word multiply.
// An end transaction waits only while the result register holds an untaken hash.
// Reset (sync, active high): mode 0, multiplier 131, hash 0, RS factor 63689, empty.
// Depends on mmsh_pkg and mmsh_fold.
module multi_mode_string_hash (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tlast,   // end_of_string
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [30:0] hash_value, [31] zero pad
   // configuration writes
   input  logic        csr_we,
   input  logic        csr_index,   // 0 mode, 1 bkdr_multiplier
   input  logic [31:0] csr_wdata
);

   // configuration registers
   mmsh_pkg::mode_type mode_ff, mode_in;
   mmsh_pkg::word_type bkdr_mult_ff, bkdr_mult_in;

   // running state
   mmsh_pkg::word_type hash_ff, hash_in;
   mmsh_pkg::word_type rs_ff, rs_in;

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [30:0] out_hash_ff, out_hash_in;

   mmsh_pkg::word_type fold_hash;
   mmsh_pkg::word_type fold_rs;

   logic advance;   // input stage item is consumed this cycle
   logic adv_end;   // consumed item is an end-of-string transaction

   mmsh_fold u_fold (
      .mode      (mode_ff),
      .bkdr_mult (bkdr_mult_ff),
      .hash_cur  (hash_ff),
      .rs_cur    (rs_ff),
      .char_byte (in_byte_ff),
      .hash_next (fold_hash),
      .rs_next   (fold_rs)
   );

   // Byte transactions always advance; an end transaction needs the
   // output register free or being drained.
   assign advance = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign adv_end = advance && in_last_ff;
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_hash_ff};

   always_comb begin
      mode_in      = mode_ff;
      bkdr_mult_in = bkdr_mult_ff;
      hash_in      = hash_ff;
      rs_in        = rs_ff;

      // input stage
      in_valid_in = in_valid_ff && !advance;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end

      // output register
      out_valid_in = out_valid_ff && !rsp_tready;
      out_hash_in  = out_hash_ff;

      if (advance) begin
         if (in_last_ff) begin
            out_valid_in = 1'b1;
            out_hash_in  = hash_ff[30:0];
            hash_in      = mmsh_pkg::initial_hash(mode_ff);
            rs_in        = mmsh_pkg::RS_START;
         end else begin
            hash_in = fold_hash;
            rs_in   = fold_rs;
         end
      end

      // Config writes must come only while idle; the block does not enforce it. A mode write restarts the string.
      if (csr_we) begin
         unique case (csr_index)
            mmsh_pkg::REG_MODE: begin
               mode_in = csr_wdata[2:0];
               hash_in = mmsh_pkg::initial_hash(csr_wdata[2:0]);
               rs_in   = mmsh_pkg::RS_START;
            end
            mmsh_pkg::REG_BKDR: begin
               bkdr_mult_in = csr_wdata;
            end
            default: begin
               bkdr_mult_in = bkdr_mult_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= mmsh_pkg::MODE_BKDR;
         bkdr_mult_ff <= mmsh_pkg::BKDR_DEFAULT;
         hash_ff      <= mmsh_pkg::initial_hash(mmsh_pkg::MODE_BKDR);
         rs_ff        <= mmsh_pkg::RS_START;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         bkdr_mult_ff <= bkdr_mult_in;
         hash_ff      <= hash_in;
         rs_ff        <= rs_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_last_ff  <= in_last_in;
      out_hash_ff <= out_hash_in;
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------

   // A result only appears after an end transaction left the input stage.
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(adv_end))
      else $error("result raised without an end transaction");

   // After a string ends the state is back at the mode's seed.
   a_reload_on_end: assert property (@(posedge clock) disable iff (reset)
      adv_end |=> (hash_ff == mmsh_pkg::initial_hash(mode_ff)) &&
                  (rs_ff == mmsh_pkg::RS_START))
      else $error("state not reloaded after end of string");

   // A held input-stage transaction is neither lost nor overwritten.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("input stage dropped or overwritten");

   // A mode write restarts the RS factor.
   a_mode_write_reload: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == mmsh_pkg::REG_MODE) |=> rs_ff == mmsh_pkg::RS_START)
      else $error("mode write did not reload state");

endmodule

@@ test/multi_mode_string_hash_tb.sv @@
// Testbench for multi_mode_string_hash: streams strings through every hash mode
// and checks each emitted hash against a predictor kept in a scoreboard class.
// Depends on mmsh_pkg and the multi_mode_string_hash RTL.
`timescale 1ns / 100ps

module multi_mode_string_hash_tb;

   // Scoreboard: keeps its own copy of the hash state and the registers,
   // queues the hash that each end-of-string transaction should produce.
   class hash_scoreboard_type;
      mmsh_pkg::mode_type mode;
      mmsh_pkg::word_type multiplier;
      mmsh_pkg::word_type running;
      mmsh_pkg::word_type rs_factor;
      logic [31:0] pending_hashes[$];
      int mismatches;

      function new();
         mode = mmsh_pkg::MODE_BKDR;
         multiplier = mmsh_pkg::BKDR_DEFAULT;
         mismatches = 0;
         reload();
      endfunction

      function mmsh_pkg::word_type seed_for(mmsh_pkg::mode_type m);
         case (m)
            mmsh_pkg::MODE_DJB: return mmsh_pkg::INIT_DJB;
            mmsh_pkg::MODE_JS:  return mmsh_pkg::INIT_JS;
            default:            return '0;
         endcase
      endfunction

      function void reload();
         running = seed_for(mode);
         rs_factor = mmsh_pkg::RS_START;
      endfunction

      function void write_reg(logic idx, mmsh_pkg::word_type value);
         if (idx == mmsh_pkg::REG_MODE) begin
            mode = value[2:0];
            reload();
         end else begin
            multiplier = value;
         end
      endfunction

      // fold one character, sign-extended like a signed char
      function mmsh_pkg::word_type fold_char(mmsh_pkg::word_type h, logic [7:0] b);
         mmsh_pkg::word_type c;
         mmsh_pkg::word_type t;
         mmsh_pkg::word_type top;
         c = {{24{b[7]}}, b};
         case (mode)
            mmsh_pkg::MODE_DJB:  return h + (h << 5) + c;
            mmsh_pkg::MODE_SDBM: return c + (h << 6) + (h << 16) - h;
            mmsh_pkg::MODE_RS: begin
               t = h * rs_factor + c;
               rs_factor = rs_factor * mmsh_pkg::RS_STEP;
               return t;
            end
            mmsh_pkg::MODE_JS:   return h ^ ((h << 5) + c + (h >> 2));
            mmsh_pkg::MODE_ELF: begin
               t = (h << 4) + c;
               top = t & mmsh_pkg::ELF_TOP;
               if (top != 0) begin
                  t = t ^ (top >> 24);
                  t = t & ~top;
               end
               return t;
            end
            default:   return h * multiplier + c;
         endcase
      endfunction

      function void note_input(logic [7:0] b, logic last);
         if (last) begin
            pending_hashes.push_back({1'b0, running[30:0]});
            reload();
         end else begin
            running = fold_char(running, b);
         end
      endfunction

      function void check_hash(logic [31:0] got);
         logic [31:0] want;
         if (pending_hashes.size() == 0) begin
            $display("%0t: unexpected hash %h with nothing pending", $realtime, got);
            mismatches++;
         end else begin
            want = pending_hashes.pop_front();
            if (got !== want) begin
               $display("%0t: hash mismatch: expected %h, got %h", $realtime, want, got);
               mismatches++;
            end
         end
      endfunction
   endclass

   // receiver stall styles, switched after a random stretch
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_RARE,
      READY_EVERY_THIRD
   } stall_style_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   hash_scoreboard_type sb = new();

   int              burst_left = 0;   // sender: transactions left in current burst
   stall_style_type stall_style = READY_ALWAYS;
   int              stall_left = 0;   // receiver: cycles left in current style

   multi_mode_string_hash i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Receiver backpressure: each style holds for a random stretch so that
   // long all-ready runs alternate with heavy stalling.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_left = $urandom_range(10, 150);
      end else begin
         stall_left--;
      end
      case (stall_style)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
         READY_RARE:   rsp_tready <= ($urandom_range(0, 4) == 0);
         default:      rsp_tready <= (stall_left % 3 == 0);
      endcase
   end

   // Result monitor: a result transaction completes at an edge with both
   // rsp_tvalid and rsp_tready high (pre-edge values read here).
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_hash(rsp_tdata);
      end
   end

   // Bias toward the sign-extension corners and the zero byte.
   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 15))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Sender pacing: bursts of random length, gaps of random length; a zero gap
   // keeps tvalid high straight into the next burst.
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 15);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Present one transaction and hold it until the block takes it.
   task automatic send_item(logic [7:0] b, logic last);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_input(b, last);
      pace();
   endtask

   // Random strings; the count may cut the last string short, which leaves
   // it in progress across the next register write.
   task automatic send_strings(int n_items);
      int sent;
      int len;
      int k;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = $urandom_range(13, 40);
            default: len = $urandom_range(1, 12);
         endcase
         for (k = 0; k < len && sent < n_items; k++) begin
            send_item(pick_char(), 1'b0);
            sent++;
         end
         if (sent < n_items) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
            sent++;
         end
      end
   endtask

   // Idle the input, wait out all pending hashes plus the pipeline depth.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending_hashes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // csr_we is raised here and lowered by the caller once all writes are done,
   // so back-to-back writes never lower and raise it in one step.
   task automatic write_reg(logic idx, mmsh_pkg::word_type value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // One setting of the registers followed by a stream of strings. A mode
   // write drops any partial string, and the first transaction after it is an
   // empty string so the new mode's seed shows up at the output.
   task automatic run_phase(bit set_mode, mmsh_pkg::mode_type m, bit set_mult,
                            mmsh_pkg::word_type mult, int n_items);
      settle();
      if (set_mult) begin
         write_reg(mmsh_pkg::REG_BKDR, mult);
      end
      if (set_mode) begin
         // upper bits of the write data are junk; only the low three count
         write_reg(mmsh_pkg::REG_MODE,
                   ($urandom() & 32'hFFFF_FFF8) | mmsh_pkg::word_type'(m));
      end
      csr_we <= 1'b0;
      if (set_mode) begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      send_strings(n_items);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= mmsh_pkg::REG_MODE;
      csr_wdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings (BKDR, multiplier 131)
      send_item(8'hA5, 1'b1);   // empty string; data ignored on the end transaction
      send_item(8'h00, 1'b0);   // zero byte without end is an ordinary byte
      send_item(8'h7F, 1'b0);
      send_item(8'h80, 1'b0);   // smallest negative char
      send_item(8'hFF, 1'b0);   // -1
      send_item(8'h01, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'h68, 1'b0);
      send_item(8'h69, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'h61, 1'b0);   // left open: multiplier changes mid-string
      send_item(8'h62, 1'b0);

      // Multiplier extremes first (no reload), then every mode incl. the
      // unused codes that fall back to BKDR.
      run_phase(1'b0, mmsh_pkg::MODE_BKDR, 1'b1, 32'h0000_0000, 100);
      run_phase(1'b0, mmsh_pkg::MODE_BKDR, 1'b1, 32'hFFFF_FFFF, 100);
      run_phase(1'b1, mmsh_pkg::MODE_DJB,  1'b0, '0, 120);
      run_phase(1'b1, mmsh_pkg::MODE_SDBM, 1'b0, '0, 120);
      run_phase(1'b1, mmsh_pkg::MODE_RS,   1'b0, '0, 120);
      run_phase(1'b1, mmsh_pkg::MODE_JS,   1'b0, '0, 120);
      run_phase(1'b1, mmsh_pkg::MODE_ELF,  1'b0, '0, 140);
      run_phase(1'b1, 3'd6,                1'b1, 32'h0000_0001, 100);
      run_phase(1'b1, 3'd7,                1'b1, $urandom(), 100);
      run_phase(1'b1, mmsh_pkg::MODE_BKDR, 1'b1, $urandom(), 120);
      run_phase(1'b1, mmsh_pkg::MODE_RS,   1'b0, '0, 140);
      run_phase(1'b1, mmsh_pkg::MODE_ELF,  1'b0, '0, 140);

      settle();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_hashes.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #1_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
